>>> src/double_ended_queue_defines.svh
// assertion macros used by the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/deq_pkg.sv
// types and constants of the double-ended queue
package deq_pkg;

    // ring depth, a power of two
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_SEARCH     = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]           mode;
        logic [WORD_BITS-1:0] value;
    } t_deq_in;

    typedef struct packed {
        logic [WORD_BITS-1:0] popped_word;
        logic                 found;
        logic [1:0]           status;
        logic [4:0]           held_count;
    } t_deq_out;

    // one access of the ring store
    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } t_mem_cmd;

endpackage

>>> src/double_ended_queue.sv
// the result strobe is registered from the EXEC state for pushes, unused modes, pops on empty
// and searches of an empty queue; pops pass through POP_WAIT for the registered ring read;
// a search passes through SRD (read) then SCMP (compare) for each entry that it compares.
// busy is high from acceptance until the result strobe cycle, when a new transaction may start.
// results cannot be stalled; synchronous reset empties the queue and sets the search mask r_mask to all
// ones, the ring words are not cleared
module double_ended_queue
    import deq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_deq_in     i_item,
    output logic        busy,
    output logic        o_done,
    output t_deq_out    o_result,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    t_mem_cmd             mem_cmd;
    logic [WORD_BITS-1:0] mem_rdata;

    deq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rdata     (mem_rdata),
        .o_cmd       (mem_cmd),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    deq_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (mem_rdata)
    );

endmodule

>>> src/deq_store.sv
// ring store of queued words, one write and one registered read per cycle
module deq_store
    import deq_pkg::*;
(
    input  logic                 i_clk,
    input  t_mem_cmd             i_cmd,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/deq_seq.sv
// sequencer: ring pointers, operation steps and the masked search compare
`include "double_ended_queue_defines.svh"

module deq_seq
    import deq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_deq_in              i_item,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic [WORD_BITS-1:0] i_rdata,
    output t_mem_cmd             o_cmd,
    output logic                 o_busy,
    output logic                 o_done,
    output t_deq_out             o_result
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_EXEC     = 5'b00010,
        S_POP_WAIT = 5'b00100,
        S_SRD      = 5'b01000,
        S_SCMP     = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_mode, n_mode;
    logic [WORD_BITS-1:0] r_value, n_value;
    logic [ADDR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [ADDR_W-1:0]    r_idx, n_idx;
    logic [31:0]          r_mask, n_mask;
    logic                 r_done, n_done;
    t_deq_out             r_result, n_result;

    logic                 full, empty, match, last;
    logic [ADDR_W-1:0]    tail_pos;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign tail_pos = r_head + r_count[ADDR_W-1:0];
    assign match    = (((i_rdata ^ r_value) & r_mask[WORD_BITS-1:0]) == '0);
    assign last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_value  = r_value;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_mask   = r_mask;
        n_done   = 1'b0;
        n_result = r_result;
        o_cmd    = '0;

        if (i_cfg_we) begin
            n_mask = i_cfg_wdata;
        end

        n_result.popped_word = '0;
        n_result.found       = 1'b0;
        n_result.status      = STATUS_DONE;
        n_result.held_count  = 5'(r_count);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode  = i_item.mode;
                    n_value = i_item.value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_mode)
                    MODE_PUSH_FRONT: begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        if (full) begin
                            n_result.status = STATUS_FULL;
                        end else begin
                            n_head      = r_head - ADDR_W'(1);
                            n_count     = r_count + CNT_W'(1);
                            o_cmd.we    = 1'b1;
                            o_cmd.waddr = r_head - ADDR_W'(1);
                            o_cmd.wdata = r_value;
                            n_result.held_count = 5'(n_count);
                        end
                    end
                    MODE_PUSH_BACK: begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        if (full) begin
                            n_result.status = STATUS_FULL;
                        end else begin
                            n_count     = r_count + CNT_W'(1);
                            o_cmd.we    = 1'b1;
                            o_cmd.waddr = tail_pos;
                            o_cmd.wdata = r_value;
                            n_result.held_count = 5'(n_count);
                        end
                    end
                    MODE_POP_FRONT: begin
                        if (empty) begin
                            n_state         = S_IDLE;
                            n_done          = 1'b1;
                            n_result.status = STATUS_EMPTY;
                        end else begin
                            o_cmd.re    = 1'b1;
                            o_cmd.raddr = r_head;
                            n_head      = r_head + ADDR_W'(1);
                            n_count     = r_count - CNT_W'(1);
                            n_state     = S_POP_WAIT;
                        end
                    end
                    MODE_POP_BACK: begin
                        if (empty) begin
                            n_state         = S_IDLE;
                            n_done          = 1'b1;
                            n_result.status = STATUS_EMPTY;
                        end else begin
                            o_cmd.re    = 1'b1;
                            o_cmd.raddr = tail_pos - ADDR_W'(1);
                            n_count     = r_count - CNT_W'(1);
                            n_state     = S_POP_WAIT;
                        end
                    end
                    MODE_SEARCH: begin
                        n_idx = '0;
                        if (empty) begin
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                    default: begin
                        // unused modes leave the queue alone
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                endcase
            end
            S_POP_WAIT: begin
                n_state              = S_IDLE;
                n_done               = 1'b1;
                n_result.popped_word = i_rdata;
            end
            S_SRD: begin
                o_cmd.re    = 1'b1;
                o_cmd.raddr = r_head + r_idx;
                n_state     = S_SCMP;
            end
            S_SCMP: begin
                if (match || last) begin
                    n_state        = S_IDLE;
                    n_done         = 1'b1;
                    n_result.found = match;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_SRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_mask  <= '1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_mask  <= n_mask;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_value  <= n_value;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    `DEQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "count above depth")
    `DEQ_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE, "result while busy")
    `DEQ_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, r_state == S_IDLE && i_start, r_state == S_EXEC, "accepted transaction not executed")
    `DEQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, r_state == S_EXEC && !full && (r_mode == MODE_PUSH_FRONT || r_mode == MODE_PUSH_BACK), r_count == $past(r_count) + CNT_W'(1) && r_done, "push did not grow queue")
    `DEQ_ASSERT_NEXT(a_scan_step, i_clk, i_rst_n, r_state == S_SCMP, r_done || r_state == S_SRD, "search step lost")

endmodule
